/* rtl/core/wsga_pkg.sv */
`default_nettype none
package wsga_pkg;

  localparam int NUM_CAMPAIGNS = 64;
  localparam int OPEN_WINDOWS  = 8;
  localparam int MAX_WORLD     = 16;
  localparam int CAMP_W        = 6;
  localparam int SLOT_W        = 3;
  localparam int POS_W         = 4;
  localparam int ENTRY_W       = SLOT_W + CAMP_W;
  localparam int DIV_STEPS     = 32;

  // register indexes
  localparam logic [0:0] REG_WORLD_SIZE = 1'b0;
  localparam logic [0:0] REG_NODE_RANK  = 1'b1;

  typedef struct packed {
    logic [31:0] seq_id;
    logic [5:0]  campaign_id;
    logic [31:0] slice_count;
    logic [31:0] slice_latency;
  } in_item_t;

  typedef struct packed {
    logic [31:0] window_id;
    logic [5:0]  out_campaign;
    logic [31:0] total_count;
    logic [31:0] max_latency;
    logic        last;
  } out_item_t;

  // classified slice handed from front to back
  typedef struct packed {
    logic [31:0]       wid;
    logic [POS_W-1:0]  pos;
    logic [SLOT_W-1:0] slot;
    logic [CAMP_W-1:0] camp;
    logic [31:0]       cnt;
    logic [31:0]       lat;
  } work_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_MUL,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_RMW,
    BK_SCAN,
    BK_READ,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

/* rtl/core/window_slice_group_aggregator.sv */
// channel | handshake         | payload
// cfg     | cfg_valid/ready   | cfg_index, cfg_data (0 world_size, 1 node_rank)
// in      | in_valid/in_stall | in_data (in_item_t)
// out     | out_valid/out_stall | out_data (out_item_t)
// front: kept slices, one at a time, go through the bit-serial 32-step window divider
// back: idle, check, rmw per slice; scan, read, emit per entry of a completed window
// a 4-deep queue sits between them; rst is synchronous and clears the table valids
// out_stall holds a result in place; the front keeps dividing until the queue fills
`default_nettype none
module window_slice_group_aggregator (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [0:0]           cfg_index,
  input  wire  [31:0]          cfg_data,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wsga_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output wsga_pkg::out_item_t  out_data
);
  import wsga_pkg::*;

  logic [4:0] world_size;
  logic [3:0] node_rank;
  logic       push, pop, q_full, q_nonempty;
  work_t      push_data, head;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      world_size <= 5'd1;
      node_rank  <= 4'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WORLD_SIZE: world_size <= cfg_data[4:0];
        REG_NODE_RANK:  node_rank  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  wsga_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .world_size, .node_rank,
    .push, .push_data, .q_full
  );

  wsga_queue u_queue (
    .clk, .rst, .push, .push_data, .full(q_full), .pop,
    .nonempty(q_nonempty), .head
  );

  wsga_back u_back (
    .clk, .rst, .nonempty(q_nonempty), .head, .pop, .world_size,
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

/* rtl/core/wsga_front.sv */
`default_nettype none
module wsga_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wsga_pkg::in_item_t   in_data,
  input  wire  [4:0]           world_size,
  input  wire  [3:0]           node_rank,
  output logic                 push,
  output wsga_pkg::work_t      push_data,
  input  wire                  q_full
);
  import wsga_pkg::*;

  front_state_t state, state_next;
  in_item_t     item;
  logic [4:0]   w_eff;
  logic [31:0]  quot;
  logic [31:0]  rem;
  logic [31:0]  dividend;
  logic [5:0]   step;
  logic [31:0]  wid;
  logic [32:0]  rem_try;
  logic         accept;

  // effective world size, clamped to 1..MAX_WORLD
  always_comb begin
    if (world_size == 5'd0) w_eff = 5'd1;
    else if (world_size > 5'(MAX_WORLD)) w_eff = 5'(MAX_WORLD);
    else w_eff = world_size;
  end

  assign accept  = in_valid && !in_stall;
  assign rem_try = {rem[31:0], dividend[31]} - {28'd0, w_eff};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: begin
        if (accept && in_data.seq_id >= {28'd0, node_rank}
            && 32'(in_data.campaign_id) < 32'(NUM_CAMPAIGNS)) state_next = FR_DIV;
      end
      FR_DIV:  if (step == 6'(DIV_STEPS - 1)) state_next = FR_MUL;
      FR_MUL:  state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state != FR_IDLE);
    push     = (state == FR_PUSH) && !q_full;
    push_data.wid  = wid;
    push_data.pos  = POS_W'(item.seq_id - wid);
    push_data.slot = quot[SLOT_W-1:0];
    push_data.camp = item.campaign_id;
    push_data.cnt  = item.slice_count;
    push_data.lat  = item.slice_latency;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= FR_IDLE;
    else state <= state_next;
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    case (state)
      FR_IDLE: begin
        item     <= in_data;
        dividend <= in_data.seq_id - {28'd0, node_rank};
        rem      <= 32'd0;
        quot     <= 32'd0;
        step     <= 6'd0;
      end
      FR_DIV: begin
        step     <= step + 6'd1;
        dividend <= {dividend[30:0], 1'b0};
        if (!rem_try[32]) begin
          rem  <= rem_try[31:0];
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= {rem[30:0], dividend[31]};
          quot <= {quot[30:0], 1'b0};
        end
      end
      FR_MUL: wid <= 32'(quot * {27'd0, w_eff}) + {28'd0, node_rank};
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/wsga_queue.sv */
`default_nettype none
module wsga_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wsga_pkg::work_t  push_data,
  output logic             full,
  input  wire              pop,
  output logic             nonempty,
  output wsga_pkg::work_t  head
);
  import wsga_pkg::*;

  work_t      mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;

  assign full     = (fill == 3'd4);
  assign nonempty = (fill != 3'd0);
  assign head     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'd0, push} - {2'd0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !nonempty |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) fill <= 3'd4)
    else $error("queue fill overflow");

endmodule
`default_nettype wire

/* rtl/core/wsga_back.sv */
`default_nettype none
module wsga_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  nonempty,
  input  wsga_pkg::work_t      head,
  output logic                 pop,
  input  wire  [4:0]           world_size,
  output logic                 out_valid,
  input  wire                  out_stall,
  output wsga_pkg::out_item_t  out_data
);
  import wsga_pkg::*;

  back_state_t state, state_next;

  logic                  win_open [OPEN_WINDOWS];
  logic [31:0]           win_tag  [OPEN_WINDOWS];
  logic [MAX_WORLD-1:0]  present  [OPEN_WINDOWS];
  logic [NUM_CAMPAIGNS-1:0] valid [OPEN_WINDOWS];
  logic [31:0]           cnt_mem  [2**ENTRY_W];
  logic [31:0]           lat_mem  [2**ENTRY_W];

  work_t             cur;
  logic [31:0]       rd_cnt, rd_lat;
  logic              was_valid;
  logic [MAX_WORLD-1:0] pres_new;
  logic [4:0]        pres_cnt;
  logic [4:0]        w_eff;
  logic [CAMP_W:0]   scan;
  logic [CAMP_W-1:0] emit_camp;
  logic [31:0]       emit_wid;
  logic              hit_any;
  logic [CAMP_W-1:0] next_camp;
  logic              more_after;
  logic [32:0]       sum;
  logic              check_ok;

  always_comb begin
    if (world_size == 5'd0) w_eff = 5'd1;
    else if (world_size > 5'(MAX_WORLD)) w_eff = 5'(MAX_WORLD);
    else w_eff = world_size;
  end

  assign check_ok = !win_open[cur.slot] || win_tag[cur.slot] == cur.wid;
  assign sum      = {1'b0, rd_cnt} + {1'b0, cur.cnt};
  assign pres_new = (win_open[cur.slot] ? present[cur.slot] : '0)
                    | (MAX_WORLD'(1) << cur.pos);
  assign pres_cnt = 5'($countones(pres_new));

  // find lowest valid campaign at or above scan
  always_comb begin
    hit_any   = 1'b0;
    next_camp = '0;
    for (int c = NUM_CAMPAIGNS - 1; c >= 0; c--) begin
      if (valid[cur.slot][c] && (CAMP_W+1)'(c) >= scan) begin
        hit_any   = 1'b1;
        next_camp = CAMP_W'(c);
      end
    end
  end

  // any valid campaign beyond the one being emitted
  always_comb begin
    more_after = 1'b0;
    for (int c = 0; c < NUM_CAMPAIGNS; c++) begin
      if (valid[cur.slot][c] && CAMP_W'(c) > emit_camp) more_after = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (nonempty) state_next = BK_CHECK;
      BK_CHECK: state_next = check_ok ? BK_RMW : BK_IDLE;
      BK_RMW:   state_next = (pres_cnt >= w_eff) ? BK_SCAN : BK_IDLE;
      BK_SCAN:  state_next = hit_any ? BK_READ : BK_IDLE;
      BK_READ:  state_next = BK_EMIT;
      BK_EMIT:  if (!out_stall) state_next = BK_SCAN;
      default:  state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop                   = (state == BK_IDLE) && nonempty;
    out_valid             = (state == BK_EMIT);
    out_data.window_id    = emit_wid;
    out_data.out_campaign = emit_camp;
    out_data.total_count  = rd_cnt;
    out_data.max_latency  = rd_lat;
    out_data.last         = !more_after;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (state == BK_CHECK || state == BK_READ) begin
      rd_cnt <= cnt_mem[{cur.slot, (state == BK_READ) ? emit_camp : cur.camp}];
      rd_lat <= lat_mem[{cur.slot, (state == BK_READ) ? emit_camp : cur.camp}];
    end
    if (state == BK_RMW) begin
      cnt_mem[{cur.slot, cur.camp}] <= !was_valid ? cur.cnt :
                                       (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
      lat_mem[{cur.slot, cur.camp}] <= (!was_valid || rd_lat < cur.lat) ? cur.lat : rd_lat;
    end
  end

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (state == BK_CHECK)
      was_valid <= win_open[cur.slot] && valid[cur.slot][cur.camp];
    if (state == BK_RMW) begin
      scan     <= '0;
      emit_wid <= cur.wid;
    end
    if (state == BK_SCAN) emit_camp <= next_camp;
    if (state == BK_EMIT && !out_stall) scan <= {1'b0, emit_camp} + 1'b1;
    if (rst) begin
      for (int s = 0; s < OPEN_WINDOWS; s++) begin
        win_open[s] <= 1'b0;
        present[s]  <= '0;
        valid[s]    <= '0;
      end
    end else begin
      if (state == BK_RMW) begin
        // a newly opened window starts with only this slice's campaign entry
        valid[cur.slot] <= (win_open[cur.slot] ? valid[cur.slot] : '0)
                           | (NUM_CAMPAIGNS'(1) << cur.camp);
        win_tag[cur.slot] <= cur.wid;
        if (pres_cnt >= w_eff) begin
          win_open[cur.slot] <= 1'b0;
          present[cur.slot]  <= '0;
        end else begin
          win_open[cur.slot] <= 1'b1;
          present[cur.slot]  <= pres_new;
        end
      end
      if (state == BK_EMIT && !out_stall) valid[cur.slot][emit_camp] <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT) |-> valid[cur.slot][emit_camp])
    else $error("emitting an entry that is not valid");
  assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN) |-> !win_open[cur.slot])
    else $error("draining a window that is still open");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last && !out_stall |=> state == BK_SCAN && !hit_any)
    else $error("last flag before end of burst");

endmodule
`default_nettype wire
